// File: sv/zfe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zfe_pkg
// shared types for the z array engine: controller states, command and status
// ----------------------------------------------------------------------------
package zfe_pkg;

    // result field widths
    localparam int POS_W = 6;
    localparam int LEN_W = 6;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_START,
        ST_SEED,
        ST_CLIP,
        ST_CMP,
        ST_CMPW,
        ST_WRITE,
        ST_OUT_RD,
        ST_OUT
    } zfe_state_t;

    typedef struct packed {
        logic load;      // byte beat accepted
        logic start;     // begin the pass
        logic clip;      // seed length from mirrored entry
        logic cmp_step;  // compare of stored bytes matched
        logic write_z;   // commit entry for current position
        logic out_sel;   // z store read follows the output position
        logic out_next;  // result beat taken
    } zfe_cmd_t;

    typedef struct packed {
        logic count_one; // string holds a single byte
        logic cmp_ok;    // extension still inside the string
        logic match;     // compared bytes are equal
        logic last_i;    // current position is the final one
    } zfe_status_t;

endpackage

// File: sv/zfe_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zfe_ctrl
// sequencer for load, z pass and result output
// ----------------------------------------------------------------------------
module zfe_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                end_of_string,
    input  logic                out_stall,
    input  zfe_pkg::zfe_status_t status,
    output zfe_pkg::zfe_cmd_t   cmd,
    output logic                in_stall,
    output logic                out_valid
);
    import zfe_pkg::*;

    zfe_state_t state_reg;
    zfe_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (in_valid && end_of_string)
                begin
                    state_next = ST_START;
                end
            end
            ST_START:  state_next = status.count_one ? ST_OUT_RD : ST_SEED;
            ST_SEED:   state_next = ST_CLIP;
            ST_CLIP:   state_next = ST_CMP;
            ST_CMP:    state_next = status.cmp_ok ? ST_CMPW : ST_WRITE;
            ST_CMPW:   state_next = status.match ? ST_CMP : ST_WRITE;
            ST_WRITE:  state_next = status.last_i ? ST_OUT_RD : ST_SEED;
            ST_OUT_RD: state_next = ST_OUT;
            ST_OUT:
            begin
                if (!out_stall)
                begin
                    state_next = status.last_i ? ST_LOAD : ST_OUT_RD;
                end
            end
            default:   state_next = ST_LOAD;
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        in_stall  = 1'b1;
        out_valid = 1'b0;
        case (state_reg)
            ST_LOAD:
            begin
                in_stall = 1'b0;
                cmd.load = in_valid;
            end
            ST_START:  cmd.start = 1'b1;
            ST_SEED:   cmd.out_sel = 1'b0;
            ST_CLIP:   cmd.clip = 1'b1;
            ST_CMP:    cmd.out_sel = 1'b0;
            ST_CMPW:   cmd.cmp_step = status.match;
            ST_WRITE:  cmd.write_z = 1'b1;
            ST_OUT_RD: cmd.out_sel = 1'b1;
            ST_OUT:
            begin
                cmd.out_sel  = 1'b1;
                out_valid    = 1'b1;
                cmd.out_next = !out_stall;
            end
            default:   cmd = '0;
        endcase
    end

endmodule

// File: sv/zfe_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zfe_datapath
// string and z stores, match window, position and length counters
// ----------------------------------------------------------------------------
module zfe_datapath
#(
    parameter int MAX_LEN = 64
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  zfe_pkg::zfe_cmd_t          cmd,
    input  logic [7:0]                 char_byte,
    output zfe_pkg::zfe_status_t       status,
    output logic [zfe_pkg::POS_W-1:0]  position,
    output logic [zfe_pkg::LEN_W-1:0]  match_length,
    output logic                       last_result,
    output logic                       overflow
);
    import zfe_pkg::*;

    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CW = $clog2(MAX_LEN + 1);

    logic [7:0]    text_mem [MAX_LEN];
    logic [AW-1:0] z_mem    [MAX_LEN];

    logic [CW-1:0] count_reg, count_next;
    logic          ovf_reg, ovf_next;
    logic [CW-1:0] i_reg, i_next;
    logic [CW-1:0] len_reg, len_next;
    logic [AW-1:0] wl_reg, wl_next;
    logic [CW-1:0] wend_reg, wend_next;

    logic [7:0]    ta_reg, tb_reg;
    logic [AW-1:0] zrd_reg;

    logic [CW-1:0] ilen;
    logic [CW-1:0] room;
    logic [CW-1:0] mirror;
    logic [AW-1:0] z_addr;
    logic          z_we;
    logic [AW-1:0] z_wa;
    logic [AW-1:0] z_wd;
    logic          text_we;

    assign ilen   = CW'(i_reg + len_reg);
    assign room   = CW'(wend_reg - i_reg);
    assign mirror = CW'(zrd_reg);
    assign z_addr = cmd.out_sel ? i_reg[AW-1:0] : AW'(i_reg[AW-1:0] - wl_reg);

    assign status.count_one = (count_reg == CW'(1));
    assign status.cmp_ok    = (ilen < count_reg);
    assign status.match     = (ta_reg == tb_reg);
    assign status.last_i    = (CW'(i_reg + CW'(1)) == count_reg);

    assign text_we = cmd.load && (count_reg < CW'(MAX_LEN));
    assign z_we    = cmd.start || cmd.write_z;
    assign z_wa    = cmd.start ? '0 : i_reg[AW-1:0];
    assign z_wd    = cmd.start ? '0 : len_reg[AW-1:0];

    always_comb
    begin
        count_next = count_reg;
        ovf_next   = ovf_reg;
        i_next     = i_reg;
        len_next   = len_reg;
        wl_next    = wl_reg;
        wend_next  = wend_reg;
        if (cmd.load)
        begin
            if (count_reg < CW'(MAX_LEN))
            begin
                count_next = CW'(count_reg + CW'(1));
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end
        if (cmd.start)
        begin
            i_next    = status.count_one ? '0 : CW'(1);
            len_next  = '0;
            wl_next   = '0;
            wend_next = '0;
        end
        if (cmd.clip)
        begin
            if (i_reg < wend_reg)
            begin
                len_next = (mirror < room) ? mirror : room;
            end
            else
            begin
                len_next = '0;
            end
        end
        if (cmd.cmp_step)
        begin
            len_next = CW'(len_reg + CW'(1));
        end
        if (cmd.write_z)
        begin
            // window reaching at least as far moves to this position
            if (ilen >= wend_reg)
            begin
                wl_next   = i_reg[AW-1:0];
                wend_next = ilen;
            end
            i_next = status.last_i ? '0 : CW'(i_reg + CW'(1));
        end
        if (cmd.out_next)
        begin
            if (status.last_i)
            begin
                count_next = '0;
                ovf_next   = 1'b0;
                i_next     = '0;
            end
            else
            begin
                i_next = CW'(i_reg + CW'(1));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            i_reg     <= '0;
            len_reg   <= '0;
            wl_reg    <= '0;
            wend_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            i_reg     <= i_next;
            len_reg   <= len_next;
            wl_reg    <= wl_next;
            wend_reg  <= wend_next;
        end
    end

    // stores with registered reads
    always_ff @(posedge clk)
    begin
        if (text_we)
        begin
            text_mem[count_reg[AW-1:0]] <= char_byte;
        end
        ta_reg <= text_mem[len_reg[AW-1:0]];
        tb_reg <= text_mem[ilen[AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (z_we)
        begin
            z_mem[z_wa] <= z_wd;
        end
        zrd_reg <= z_mem[z_addr];
    end

    assign position     = POS_W'(i_reg[AW-1:0]);
    assign match_length = LEN_W'(zrd_reg);
    assign last_result  = status.last_i;
    assign overflow     = ovf_reg;

endmodule

// File: sv/z_function_engine_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// z_function_engine_unit
// z array of a byte string, one result beat per stored position
// ----------------------------------------------------------------------------
// bytes stream in one beat per cycle and are kept in an on-chip store of
// MAX_LEN entries; bytes past that depth are dropped and every result of the
// string then carries overflow. the beat flagged end_of_string closes the
// string and starts the z pass; no input beat is taken until the last result
// beat of that string has been delivered. the pass is a start step and then
// one controller loop over positions 1 to n-1: per position a mirror read,
// clip, compare check and commit, plus a compare wait and a further compare
// check for every matching byte compare and a compare wait for the mismatching
// compare that ends an extension, as the string store reads are registered.
// matching compares total at most n over the string. results then leave as a
// z store read and then the beat for each position, in position order with
// last_result on the final one; match_length is 0 at position 0.
// ----------------------------------------------------------------------------
module z_function_engine_unit
#(
    parameter int MAX_LEN = 64
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    // byte input
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [7:0]                 char_byte,
    input  logic                       end_of_string,
    // result output
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [zfe_pkg::POS_W-1:0]  position,
    output logic [zfe_pkg::LEN_W-1:0]  match_length,
    output logic                       last_result,
    output logic                       overflow
);
    import zfe_pkg::*;

    // command and status between sequencer and datapath
    zfe_cmd_t    cmd;
    zfe_status_t status;

    // sequencer: load, per-position seed / compare / commit, result beats
    zfe_ctrl u_ctrl
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .end_of_string (end_of_string),
        .out_stall     (out_stall),
        .status        (status),
        .cmd           (cmd),
        .in_stall      (in_stall),
        .out_valid     (out_valid)
    );

    // stores, match window and counters
    zfe_datapath #(
        .MAX_LEN (MAX_LEN)
    ) u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .char_byte    (char_byte),
        .status       (status),
        .position     (position),
        .match_length (match_length),
        .last_result  (last_result),
        .overflow     (overflow)
    );

endmodule

// File: dv/zfe_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zfe_checker
// watches both channels of the z array engine, predicts and compares results
// ----------------------------------------------------------------------------
module zfe_checker
#(
    parameter int MAX_LEN = 64
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic                       in_stall,
    input  logic [7:0]                 char_byte,
    input  logic                       end_of_string,
    input  logic                       out_valid,
    input  logic                       out_stall,
    input  logic [zfe_pkg::POS_W-1:0]  position,
    input  logic [zfe_pkg::LEN_W-1:0]  match_length,
    input  logic                       last_result,
    input  logic                       overflow,
    output int                         fail_count,
    output int                         pending
);
    import zfe_pkg::*;

    typedef struct {
        logic [POS_W-1:0] pos;
        logic [LEN_W-1:0] len;
        logic             last;
        logic             ovf;
    } zfe_beat_t;

    logic [7:0]  text_copy [0:MAX_LEN-1];
    int          stored_bytes;
    logic        dropped_byte;
    zfe_beat_t   z_expected [$];

    initial
    begin
        fail_count   = 0;
        pending      = 0;
        stored_bytes = 0;
        dropped_byte = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("%0t ns: mismatch: %s", $realtime, msg);
        fail_count++;
    endtask

    // linear z pass over the stored string, one expected beat per position
    function automatic void queue_z_entries();
        logic [LEN_W-1:0] z_len [0:MAX_LEN-1];
        int        i;
        int        len;
        int        win_left;
        int        win_end;
        int        room;
        int        mirror;
        zfe_beat_t beat;
        win_left = 0;
        z_len[0] = '0;
        for (i = 1; i < stored_bytes; i++)
        begin
            len     = 0;
            win_end = win_left + int'(z_len[win_left]);
            if (i < win_end)
            begin
                // seed from the mirrored entry, clipped to the window end
                room   = win_end - i;
                mirror = int'(z_len[i - win_left]);
                len    = (mirror < room) ? mirror : room;
            end
            while (i + len < stored_bytes && text_copy[len] == text_copy[i + len])
                len++;
            z_len[i] = len[LEN_W-1:0];
            if (i + len >= win_end)
                win_left = i;
        end
        for (i = 0; i < stored_bytes; i++)
        begin
            beat.pos  = i[POS_W-1:0];
            beat.len  = z_len[i];
            beat.last = (i + 1 == stored_bytes);
            beat.ovf  = dropped_byte;
            z_expected = {z_expected, beat};
        end
    endfunction

    always @(posedge clk)
    begin
        zfe_beat_t want;
        if (rst_n)
        begin
            // byte beat: store or drop, close the string on the end flag
            if (in_valid && !in_stall)
            begin
                if (stored_bytes < MAX_LEN)
                begin
                    text_copy[stored_bytes] = char_byte;
                    stored_bytes++;
                end
                else
                    dropped_byte = 1'b1;
                if (end_of_string)
                begin
                    queue_z_entries();
                    stored_bytes = 0;
                    dropped_byte = 1'b0;
                end
            end
            // result beat
            if (out_valid && !out_stall)
            begin
                if (z_expected.size() == 0)
                    report_mismatch($sformatf("result beat pos=%0d with none expected",
                                              position));
                else
                begin
                    want = z_expected.pop_front();
                    if (position !== want.pos)
                        report_mismatch($sformatf("position got %0d want %0d",
                                                  position, want.pos));
                    if (match_length !== want.len)
                        report_mismatch($sformatf("match_length at %0d got %0d want %0d",
                                                  want.pos, match_length, want.len));
                    if (last_result !== want.last)
                        report_mismatch($sformatf("last_result at %0d got %0b want %0b",
                                                  want.pos, last_result, want.last));
                    if (overflow !== want.ovf)
                        report_mismatch($sformatf("overflow at %0d got %0b want %0b",
                                                  want.pos, overflow, want.ovf));
                end
            end
            pending = z_expected.size();
        end
    end

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// stimulus and verdict for the z array engine
// ----------------------------------------------------------------------------
// strings go in one byte beat at a time; the checker beside the block predicts
// the z array of every closed string and compares each result beat. a short
// directed set comes first, then random strings over small alphabets, periodic
// patterns and full random bytes, with a few strings at and past the store
// depth. both sides idle at random, the receiver holds off once for a long
// stretch and the sender once waits for every outstanding result.
// ----------------------------------------------------------------------------
module tb;

    import zfe_pkg::*;

    localparam int MAX_LEN      = 64;
    localparam int CLK_HALF     = 4;
    localparam int RESET_CYCLES = 12;
    localparam int ITEM_TARGET  = 410;
    localparam int MAX_GAP      = 16;
    localparam int LONG_HOLD    = 300;   // receiver hold-off, in cycles
    localparam int HOLD_AT_BEAT = 40;
    localparam int PAUSE_STRING = 12;    // sender waits for all results here
    localparam int DRAIN_CYCLES = 60;
    localparam int TIMEOUT_NS   = 3000000;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic [7:0]          char_byte;
    logic                end_of_string;
    logic                out_valid;
    logic                out_stall;
    logic [POS_W-1:0]    position;
    logic [LEN_W-1:0]    match_length;
    logic                last_result;
    logic                overflow;
    int                  fail_count;
    int                  pending;

    logic [7:0]          str_buf [0:79];
    int                  items_sent;

    z_function_engine_unit #(.MAX_LEN(MAX_LEN)) uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .char_byte     (char_byte),
        .end_of_string (end_of_string),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .position      (position),
        .match_length  (match_length),
        .last_result   (last_result),
        .overflow      (overflow)
    );

    zfe_checker #(.MAX_LEN(MAX_LEN)) u_checker
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .char_byte     (char_byte),
        .end_of_string (end_of_string),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .position      (position),
        .match_length  (match_length),
        .last_result   (last_result),
        .overflow      (overflow),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // hard stop in case the block hangs
    initial
    begin
        #(TIMEOUT_NS);
        $display("TEST FAILED");
        $finish;
    end

    // one byte beat: optional idle gap (and optional wait for an empty
    // prediction queue) with valid low, then offer until accepted
    task automatic send_beat(input logic [7:0] b, input logic eos, input int gap,
                             input bit drain_first);
        if (gap > 0 || drain_first)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            if (drain_first)
                wait (pending == 0);
            repeat (gap) @(negedge clk);
        end
        @(negedge clk);
        in_valid      <= 1'b1;
        char_byte     <= b;
        end_of_string <= eos;
        do @(posedge clk); while (!(in_valid && !in_stall));
    endtask

    // sends str_buf[0..len-1]; a quiet string sends back to back
    task automatic send_string(input int len, input bit drain_first);
        bit quiet;
        int k;
        quiet = ($urandom_range(0, 3) == 0);
        for (k = 0; k < len; k++)
            send_beat(str_buf[k], (k == len - 1), quiet ? 0 : $urandom_range(0, MAX_GAP),
                      drain_first && (k == 0));
        items_sent += len;
    endtask

    // directed strings packed msb first, up to eight bytes
    task automatic send_packed(input logic [63:0] bytes, input int len);
        int k;
        for (k = 0; k < len; k++)
            str_buf[k] = bytes[8*(len-1-k) +: 8];
        send_string(len, 1'b0);
    endtask

    // random content: two or three symbol alphabets give long matches,
    // periodic patterns exercise the window seeding, raw bytes the rest
    task automatic make_string(input int len, input bit uniform);
        logic [7:0] alphabet [0:3];
        int         style;
        int         period;
        int         k;
        style  = $urandom_range(0, 3);
        period = $urandom_range(1, 4);
        for (k = 0; k < 4; k++)
            alphabet[k] = 8'($urandom_range(0, 255));
        for (k = 0; k < len; k++)
        begin
            if (uniform)
                str_buf[k] = alphabet[0];
            else
                case (style)
                    0:       str_buf[k] = alphabet[$urandom_range(0, 1)];
                    1:       str_buf[k] = alphabet[$urandom_range(0, 2)];
                    2:       str_buf[k] = 8'($urandom_range(0, 255));
                    default: str_buf[k] = ($urandom_range(0, 9) == 0) ? alphabet[3]
                                                                       : alphabet[k % period];
                endcase
        end
    endtask

    // receiver: random stall before each beat, quiet stretches, one long hold
    initial
    begin : receiver
        int  wait_cycles;
        int  beats;
        bit  quiet;
        out_stall = 1'b0;
        beats     = 0;
        quiet     = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (beats % 32 == 0)
                quiet = ($urandom_range(0, 3) == 0);
            wait_cycles = quiet ? 0 : $urandom_range(0, MAX_GAP);
            // long hold so the block backs up and stalls its byte input
            if (beats == HOLD_AT_BEAT)
                wait_cycles = LONG_HOLD;
            repeat (wait_cycles)
            begin
                @(negedge clk);
                out_stall <= 1'b1;
            end
            @(negedge clk);
            out_stall <= 1'b0;
            do @(posedge clk); while (!(out_valid && !out_stall));
            beats++;
        end
    end

    // stimulus and verdict
    initial
    begin
        int len;
        int str_idx;
        bit uniform;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        char_byte     = 8'h00;
        end_of_string = 1'b0;
        items_sent    = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // single byte strings at both byte extremes
        send_packed(64'h00, 1);
        send_packed(64'hFF, 1);
        // run of equal bytes: mirrored seeds clipped at the window end
        send_packed(64'h00000000, 4);
        // alternating extremes
        send_packed(64'hFF00FF00FF, 5);
        // nested windows
        send_packed(64'h61626163616261, 7);
        // match that breaks on the last byte
        send_packed(64'h616162616163, 6);

        str_idx = 0;
        while (items_sent < ITEM_TARGET)
        begin
            uniform = 1'b0;
            case (str_idx)
                3:       len = MAX_LEN;          // store exactly full
                9:       len = MAX_LEN + 2;      // bytes dropped, end flag too
                15:
                begin
                    len     = MAX_LEN;           // longest possible match length
                    uniform = 1'b1;
                end
                22:      len = MAX_LEN + $urandom_range(1, 6);
                default: len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                           : $urandom_range(1, 12);
            endcase
            make_string(len, uniform);
            send_string(len, str_idx == PAUSE_STRING);
            str_idx++;
        end
        @(negedge clk);
        in_valid <= 1'b0;

        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
